// File: rtl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and codes of the best-fit partition allocator: request and
// response transactions, action and status codes, cell control and probe.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int DEF_MAX_PARTITIONS = 8;
    localparam logic [15:0] MEMORY_TOTAL_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_DEFINE = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_CLOSED    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALLOC_IDLE,
        ALLOC_SCAN,
        ALLOC_GRANT
    } alloc_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] amount;
        logic [3:0]  partition_number;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  granted_index;
        logic [15:0] space_left;
        logic [3:0]  partitions_defined;
    } rsp_item_t;

    // Write strobes from the allocator control to one cell
    typedef struct packed {
        logic define_we;
        logic free_we;
        logic grant_we;
    } cell_ctrl_t;

    // Running best-fit candidate handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [15:0] size;
    } probe_t;

endpackage

// File: rtl/bfpa_cell.sv
// ----------------------------------------------------------------------------
// bfpa_cell
// One partition slot: holds its defined size and the size it currently holds,
// and refines the best-fit probe passing through on its way down the row.
// ----------------------------------------------------------------------------
module bfpa_cell #(
    parameter int IDX_W      = 3,
    parameter int CELL_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfpa_pkg::cell_ctrl_t ctrl,
    input  logic [15:0]          wdata,
    input  logic [15:0]          amount,
    input  bfpa_pkg::probe_t     probe_in,
    input  logic [IDX_W-1:0]     idx_in,
    output bfpa_pkg::probe_t     probe_out,
    output logic [IDX_W-1:0]     idx_out
);
    import bfpa_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic             defined_reg;
    logic             defined_next;
    logic [15:0]      size_reg;
    logic [15:0]      size_next;
    logic [15:0]      held_reg;
    logic [15:0]      held_next;
    logic             probe_valid_reg;
    logic             probe_found_reg;
    logic [15:0]      probe_size_reg;
    probe_t           probe_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             candidate;
    logic             take;

    // Slot contents: define writes size and frees, free clears, grant records
    always_comb
    begin
        defined_next = defined_reg;
        size_next    = size_reg;
        held_next    = held_reg;
        if (ctrl.define_we)
        begin
            defined_next = 1'b1;
            size_next    = wdata;
            held_next    = '0;
        end
        else if (ctrl.free_we)
        begin
            held_next = '0;
        end
        else if (ctrl.grant_we)
        begin
            held_next = wdata;
        end
    end

    // Compare this slot against the running best; strict less keeps the lower index
    assign candidate = probe_in.valid && defined_reg && (held_reg == '0) &&
                       (size_reg >= amount);
    assign take      = candidate && (!probe_in.found || (size_reg < probe_in.size));

    always_comb
    begin
        probe_next.valid = probe_in.valid;
        probe_next.found = probe_in.found || take;
        probe_next.size  = take ? size_reg : probe_in.size;
        idx_next         = take ? MY_INDEX : idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defined_reg     <= 1'b0;
            held_reg        <= '0;
            probe_valid_reg <= 1'b0;
            probe_found_reg <= 1'b0;
        end
        else
        begin
            defined_reg     <= defined_next;
            held_reg        <= held_next;
            probe_valid_reg <= probe_next.valid;
            probe_found_reg <= probe_next.found;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        probe_size_reg <= probe_next.size;
        idx_reg        <= idx_next;
    end

    assign probe_out = {probe_valid_reg, probe_found_reg, probe_size_reg};
    assign idx_out   = idx_reg;

    // Once a fit is found upstream it is never lost
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        probe_in.valid && probe_in.found |=> probe_out.found)
        else $error("bfpa_cell: probe lost its fit");

    // A slot that wins the compare names itself downstream
    a_take_index: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (idx_out == MY_INDEX) && (probe_out.size == size_reg))
        else $error("bfpa_cell: winning slot not forwarded");

    // A freshly defined slot is free
    a_define_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.define_we |=> defined_reg && (held_reg == '0))
        else $error("bfpa_cell: defined slot not free");

endmodule

// File: rtl/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Fixed-partition memory allocator with a best-fit store policy.
// ----------------------------------------------------------------------------
// Partitions are kept in a row of MAX_PARTITIONS slot cells. Define, free and
// undefined actions finish in the cycle they are accepted, so the response is
// registered in the cycle after. A store of nonzero size launches a probe that
// walks the row one cell per clock; its result is captured at the row's end
// and its grant is loaded into the response register once the output is free.
// One request is in flight at a time; a new request is held off while a
// response waits unaccepted in the response register, and for the whole of a
// store until its grant has been loaded into that register.
module best_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = bfpa_pkg::DEF_MAX_PARTITIONS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_stall,
    input  bfpa_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bfpa_pkg::rsp_item_t rsp
);
    import bfpa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W = ((CNT_W > 4) ? CNT_W : 4) + 1;
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_PARTITIONS);

    alloc_state_t     state_reg;
    alloc_state_t     state_next;
    logic [15:0]      memory_total_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [15:0]      total_reg;
    logic [15:0]      total_next;
    logic             closed_reg;
    logic             closed_next;
    logic [15:0]      amount_reg;
    logic             launch_reg;
    logic             launch_next;
    logic             found_reg;
    logic [IDX_W-1:0] best_reg;
    rsp_item_t        rsp_reg;
    rsp_item_t        rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic             req_fire;
    logic             out_free;
    logic             grant_fire;
    logic             scan_start;
    logic             result_load;
    logic             define_ok;
    logic             free_ok;
    logic [16:0]      define_sum;
    logic [CMP_W-1:0] pnum_ext;
    logic [CMP_W-1:0] count_ext;
    logic [15:0]      wdata;
    logic [1:0]       status_now;
    logic [IDX_W+2:0] granted_wide;
    logic [CNT_W+3:0] count_wide;

    cell_ctrl_t       cell_ctrl [MAX_PARTITIONS];
    probe_t           probe_link [MAX_PARTITIONS+1];
    logic [IDX_W-1:0] idx_link [MAX_PARTITIONS+1];

    // ---------------- handshake ----------------
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_fire   = req_valid && !req_stall;
    assign scan_start = req_fire && (req.action == ACT_STORE) && (req.amount != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ALLOC_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = ALLOC_SCAN;
                end
            end
            ALLOC_SCAN:
            begin
                if (probe_link[MAX_PARTITIONS].valid)
                begin
                    state_next = ALLOC_GRANT;
                end
            end
            ALLOC_GRANT:
            begin
                if (out_free)
                begin
                    state_next = ALLOC_IDLE;
                end
            end
            default:
            begin
                state_next = ALLOC_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req_stall  = 1'b1;
        grant_fire = 1'b0;
        case (state_reg)
            ALLOC_IDLE:
            begin
                req_stall = !out_free;
            end
            ALLOC_SCAN:
            begin
                req_stall = 1'b1;
            end
            ALLOC_GRANT:
            begin
                grant_fire = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // ---------------- request decode ----------------
    assign define_sum = {1'b0, total_reg} + {1'b0, req.amount};
    assign pnum_ext   = CMP_W'(req.partition_number);
    assign count_ext  = CMP_W'(count_reg);
    assign define_ok  = req_fire && (req.action == ACT_DEFINE) && !closed_reg &&
                        (count_reg != COUNT_FULL) &&
                        (define_sum <= {1'b0, memory_total_reg});
    assign free_ok    = req_fire && (req.action == ACT_FREE) &&
                        (pnum_ext != '0) && (pnum_ext <= count_ext);
    assign launch_next = scan_start;

    // Status of an item that finishes at acceptance
    always_comb
    begin
        status_now = ST_OK;
        case (req.action)
            ACT_DEFINE:
            begin
                if (closed_reg)
                begin
                    status_now = ST_CLOSED;
                end
                else if (!define_ok)
                begin
                    status_now = ST_NO_FIT;
                end
            end
            ACT_STORE:
            begin
                status_now = ST_NO_FIT;
            end
            ACT_FREE:
            begin
                if (!free_ok)
                begin
                    status_now = ST_BAD_INDEX;
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    // Table bookkeeping
    always_comb
    begin
        count_next  = count_reg;
        total_next  = total_reg;
        closed_next = closed_reg;
        if (define_ok)
        begin
            count_next = count_reg + 1'b1;
            total_next = define_sum[15:0];
        end
        if (req_fire && ((req.action == ACT_STORE) || (req.action == ACT_FREE)))
        begin
            closed_next = 1'b1;
        end
    end

    // ---------------- response ----------------
    assign result_load  = (req_fire && !scan_start) || grant_fire;
    assign granted_wide = {3'b000, best_reg};
    assign count_wide   = {4'b0000, count_next};

    always_comb
    begin
        rsp_next = rsp_reg;
        if (result_load)
        begin
            rsp_next.partitions_defined = count_wide[3:0];
            rsp_next.space_left = (total_next > memory_total_reg) ? 16'd0
                                                                  : memory_total_reg - total_next;
            if (grant_fire)
            begin
                rsp_next.status        = found_reg ? ST_OK : ST_NO_FIT;
                rsp_next.granted_index = found_reg ? granted_wide[2:0] : 3'd0;
            end
            else
            begin
                rsp_next.status        = status_now;
                rsp_next.granted_index = 3'd0;
            end
        end
    end

    assign rsp_valid_next = result_load || (rsp_valid_reg && rsp_stall);

    // ---------------- cell row ----------------
    assign wdata = (state_reg == ALLOC_GRANT) ? amount_reg : req.amount;

    assign probe_link[0].valid = launch_reg;
    assign probe_link[0].found = 1'b0;
    assign probe_link[0].size  = '0;
    assign idx_link[0]         = '0;

    for (genvar i = 0; i < MAX_PARTITIONS; i++)
    begin : g_cell
        assign cell_ctrl[i].define_we = define_ok && (count_reg == CNT_W'(i));
        assign cell_ctrl[i].free_we   = free_ok && (pnum_ext == CMP_W'(i + 1));
        assign cell_ctrl[i].grant_we  = grant_fire && found_reg && (best_reg == IDX_W'(i));

        bfpa_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .wdata     (wdata),
            .amount    (amount_reg),
            .probe_in  (probe_link[i]),
            .idx_in    (idx_link[i]),
            .probe_out (probe_link[i+1]),
            .idx_out   (idx_link[i+1])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ALLOC_IDLE;
            memory_total_reg <= MEMORY_TOTAL_RESET;
            count_reg        <= '0;
            total_reg        <= '0;
            closed_reg       <= 1'b0;
            launch_reg       <= 1'b0;
            found_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            closed_reg    <= closed_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                memory_total_reg <= cfg_data;
            end
            if ((state_reg == ALLOC_SCAN) && probe_link[MAX_PARTITIONS].valid)
            begin
                found_reg <= probe_link[MAX_PARTITIONS].found;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_fire)
        begin
            amount_reg <= req.amount;
        end
        if ((state_reg == ALLOC_SCAN) && probe_link[MAX_PARTITIONS].valid)
        begin
            best_reg <= idx_link[MAX_PARTITIONS];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- checks ----------------
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ALLOC_IDLE) |-> req_stall)
        else $error("allocator: request taken during a store");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("allocator: partition count overflow");

    a_probe_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        probe_link[MAX_PARTITIONS].valid |-> (state_reg == ALLOC_SCAN))
        else $error("allocator: probe arrived outside a scan");

    a_define_closed: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg && $stable(count_reg))
        else $error("allocator: table changed after setup closed");

endmodule
